/* hdl/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of i_clk, switched off while reset is applied.
`define LFU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define LFU_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* hdl/lfu_pkg.sv */
package lfu_pkg;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CNT_W = 16;
    localparam int CAP_W = 5;

    // opcode of an input item
    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_WRITE  = 1'b1;

    // update command broadcast to the cells
    localparam logic [1:0] CMD_NONE   = 2'd0;
    localparam logic [1:0] CMD_BUMP   = 2'd1;
    localparam logic [1:0] CMD_INSERT = 2'd2;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // running result of the search as it passes along the row
    typedef struct packed {
        logic             found;
        logic             vic_found;
        logic             free_found;
        logic [VAL_W-1:0] hit_value;
        logic [CNT_W-1:0] vic_count;
    } t_carry;

    typedef struct packed {
        logic [1:0]       kind;
        logic             is_write;
        logic             evict;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_cmd;

endpackage

/* hdl/lfu_cell.sv */
module lfu_cell #(
    parameter int ENTRIES = 16,
    parameter int IDX     = 0,
    localparam int IW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
    localparam int CW     = $clog2(ENTRIES + 1)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // search pass
    input  logic [lfu_pkg::KEY_W-1:0] i_key,
    input  logic                      i_tok,
    input  lfu_pkg::t_carry           i_carry,
    input  logic [IW-1:0]             i_hit_idx,
    input  logic [IW-1:0]             i_hit_rank,
    input  logic [IW-1:0]             i_vic_idx,
    input  logic [IW-1:0]             i_vic_rank,
    input  logic [IW-1:0]             i_free_idx,
    input  logic [CW-1:0]             i_nvalid,
    output logic                      o_tok,
    output lfu_pkg::t_carry           o_carry,
    output logic [IW-1:0]             o_hit_idx,
    output logic [IW-1:0]             o_hit_rank,
    output logic [IW-1:0]             o_vic_idx,
    output logic [IW-1:0]             o_vic_rank,
    output logic [IW-1:0]             o_free_idx,
    output logic [CW-1:0]             o_nvalid,
    // update broadcast
    input  logic                      i_cmd_en,
    input  lfu_pkg::t_cmd             i_cmd,
    input  logic [IW-1:0]             i_cmd_idx,
    input  logic [IW-1:0]             i_cmd_rank,
    input  logic [IW-1:0]             i_cmd_vidx,
    input  logic [IW-1:0]             i_cmd_vrank
);
    import lfu_pkg::*;

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic             r_valid;
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_value;
    logic [CNT_W-1:0] r_count;
    logic [IW-1:0]    r_rank;

    logic             r_tok;
    t_carry           r_carry;
    logic [IW-1:0]    r_hit_idx;
    logic [IW-1:0]    r_hit_rank;
    logic [IW-1:0]    r_vic_idx;
    logic [IW-1:0]    r_vic_rank;
    logic [IW-1:0]    r_free_idx;
    logic [CW-1:0]    r_nvalid;

    t_carry           n_carry;
    logic [IW-1:0]    n_hit_idx;
    logic [IW-1:0]    n_hit_rank;
    logic [IW-1:0]    n_vic_idx;
    logic [IW-1:0]    n_vic_rank;
    logic [IW-1:0]    n_free_idx;

    logic w_match;
    logic w_better;
    logic w_older_victim;

    assign w_match = r_valid && (r_key == i_key);
    assign w_better = r_valid && (!i_carry.vic_found || (r_count < i_carry.vic_count) ||
                      ((r_count == i_carry.vic_count) && (r_rank > i_vic_rank)));
    assign w_older_victim = i_cmd.evict && (r_rank > i_cmd_vrank);

    // search step: fold this entry into the running result
    always_comb begin
        n_carry    = i_carry;
        n_hit_idx  = i_hit_idx;
        n_hit_rank = i_hit_rank;
        n_vic_idx  = i_vic_idx;
        n_vic_rank = i_vic_rank;
        n_free_idx = i_free_idx;
        if (!i_carry.found && w_match) begin
            n_carry.found     = 1'b1;
            n_carry.hit_value = r_value;
            n_hit_idx         = MY_IDX;
            n_hit_rank        = r_rank;
        end
        if (w_better) begin
            n_carry.vic_found = 1'b1;
            n_carry.vic_count = r_count;
            n_vic_idx         = MY_IDX;
            n_vic_rank        = r_rank;
        end
        if (!i_carry.free_found && !r_valid) begin
            n_carry.free_found = 1'b1;
            n_free_idx         = MY_IDX;
        end
    end

    // hand the token and the running result on to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= 1'b0;
        end else begin
            r_tok <= i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tok) begin
            r_carry    <= n_carry;
            r_hit_idx  <= n_hit_idx;
            r_hit_rank <= n_hit_rank;
            r_vic_idx  <= n_vic_idx;
            r_vic_rank <= n_vic_rank;
            r_free_idx <= n_free_idx;
            r_nvalid   <= i_nvalid + CW'(r_valid);
        end
    end

    // entry valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd_en && (i_cmd.kind == CMD_INSERT)) begin
            if (i_cmd_idx == MY_IDX) begin
                r_valid <= 1'b1;
            end else if (i_cmd.evict && (i_cmd_vidx == MY_IDX)) begin
                r_valid <= 1'b0;
            end
        end
    end

    // entry payload: bump on a hit, fill on insert, age the ranks of the rest
    always_ff @(posedge i_clk) begin
        if (i_cmd_en) begin
            case (i_cmd.kind)
                CMD_BUMP: begin
                    if (i_cmd_idx == MY_IDX) begin
                        if (r_count != '1) begin
                            r_count <= r_count + CNT_W'(1);
                        end
                        r_rank <= '0;
                        if (i_cmd.is_write) begin
                            r_value <= i_cmd.value;
                        end
                    end else if (r_valid && (r_rank < i_cmd_rank)) begin
                        r_rank <= r_rank + IW'(1);
                    end
                end
                CMD_INSERT: begin
                    if (i_cmd_idx == MY_IDX) begin
                        r_key   <= i_cmd.key;
                        r_value <= i_cmd.value;
                        r_count <= CNT_W'(1);
                        r_rank  <= '0;
                    end else if (r_valid && !(i_cmd.evict && (i_cmd_vidx == MY_IDX))) begin
                        r_rank <= r_rank - IW'(w_older_victim) + IW'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_tok      = r_tok;
    assign o_carry    = r_carry;
    assign o_hit_idx  = r_hit_idx;
    assign o_hit_rank = r_hit_rank;
    assign o_vic_idx  = r_vic_idx;
    assign o_vic_rank = r_vic_rank;
    assign o_free_idx = r_free_idx;
    assign o_nvalid   = r_nvalid;

endmodule

/* hdl/lfu_cache.sv */
// An accepted input item passes through these registered steps in order: the start
// register launches the token, each cell's register carries the sweep along the row,
// the decision is latched, the update is applied and the output register is loaded.
// A new item is taken only once the last result is loaded; a stalled output holds the next item.
// Reset (synchronous, active low): all entries invalid, capacity 16, no item in flight.
`include "assert_macros.svh"

module lfu_cache #(
    parameter int ENTRIES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // capacity_in_use
    input  logic        i_cfg_wen,
    input  logic [4:0]  i_cfg_wdata,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,  // [31:0] key, [63:32] write_value
    input  logic        i_s_tuser,  // [0] opcode
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,  // [31:0] read_value
    output logic        o_m_tuser   // [0] hit
);
    import lfu_pkg::*;

    localparam int IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW   = $clog2(ENTRIES + 1);
    localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SWEEP = 2'd1;
    localparam logic [1:0] ST_UPD   = 2'd2;
    localparam logic [1:0] ST_RESP  = 2'd3;

    logic [1:0]       r_state;
    logic [1:0]       n_state;
    logic [CAP_W-1:0] r_capacity;
    logic             r_start;
    logic             r_op;
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_wval;
    logic             r_hit;
    logic [VAL_W-1:0] r_rdval;
    logic             r_out_valid;
    logic             r_out_hit;
    logic [VAL_W-1:0] r_out_data;

    t_cmd             r_cmd;
    logic [IW-1:0]    r_cmd_idx;
    logic [IW-1:0]    r_cmd_rank;
    logic [IW-1:0]    r_cmd_vidx;
    logic [IW-1:0]    r_cmd_vrank;

    // chain links, entry 0 fed with an empty result
    logic          w_tok       [ENTRIES+1];
    t_carry        w_carry     [ENTRIES+1];
    logic [IW-1:0] w_hit_idx   [ENTRIES+1];
    logic [IW-1:0] w_hit_rank  [ENTRIES+1];
    logic [IW-1:0] w_vic_idx   [ENTRIES+1];
    logic [IW-1:0] w_vic_rank  [ENTRIES+1];
    logic [IW-1:0] w_free_idx  [ENTRIES+1];
    logic [CW-1:0] w_nvalid    [ENTRIES+1];

    logic             w_accept;
    logic             w_last;
    logic             w_out_load;
    logic [CMPW-1:0]  w_cap_eff;
    logic             w_evict;
    logic [IW-1:0]    w_ins_idx;
    t_carry           w_res;

    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_last     = w_tok[ENTRIES];
    assign w_res      = w_carry[ENTRIES];
    assign w_out_load = (r_state == ST_RESP) && (!r_out_valid || i_m_tready);

    assign w_tok[0]      = r_start;
    assign w_carry[0]    = '0;
    assign w_hit_idx[0]  = '0;
    assign w_hit_rank[0] = '0;
    assign w_vic_idx[0]  = '0;
    assign w_vic_rank[0] = '0;
    assign w_free_idx[0] = '0;
    assign w_nvalid[0]   = '0;

    // row of entry cells
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        lfu_cell #(
            .ENTRIES (ENTRIES),
            .IDX     (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_key       (r_key),
            .i_tok       (w_tok[g]),
            .i_carry     (w_carry[g]),
            .i_hit_idx   (w_hit_idx[g]),
            .i_hit_rank  (w_hit_rank[g]),
            .i_vic_idx   (w_vic_idx[g]),
            .i_vic_rank  (w_vic_rank[g]),
            .i_free_idx  (w_free_idx[g]),
            .i_nvalid    (w_nvalid[g]),
            .o_tok       (w_tok[g+1]),
            .o_carry     (w_carry[g+1]),
            .o_hit_idx   (w_hit_idx[g+1]),
            .o_hit_rank  (w_hit_rank[g+1]),
            .o_vic_idx   (w_vic_idx[g+1]),
            .o_vic_rank  (w_vic_rank[g+1]),
            .o_free_idx  (w_free_idx[g+1]),
            .o_nvalid    (w_nvalid[g+1]),
            .i_cmd_en    (r_state == ST_UPD),
            .i_cmd       (r_cmd),
            .i_cmd_idx   (r_cmd_idx),
            .i_cmd_rank  (r_cmd_rank),
            .i_cmd_vidx  (r_cmd_vidx),
            .i_cmd_vrank (r_cmd_vrank)
        );
    end

    // capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (i_cfg_wen) begin
            r_capacity <= i_cfg_wdata;
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (w_accept) n_state = ST_SWEEP;
            ST_SWEEP: if (w_last) n_state = ST_UPD;
            ST_UPD:   n_state = ST_RESP;
            ST_RESP:  if (w_out_load) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_start <= 1'b0;
        end else begin
            r_state <= n_state;
            r_start <= w_accept;
        end
    end

    // input capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op   <= i_s_tuser;
            r_key  <= i_s_tdata[31:0];
            r_wval <= i_s_tdata[63:32];
        end
    end

    // replacement decision from the finished search
    assign w_cap_eff = (CMPW'(r_capacity) > CMPW'(ENTRIES)) ? CMPW'(ENTRIES)
                                                            : CMPW'(r_capacity);
    assign w_evict   = (CMPW'(w_nvalid[ENTRIES]) >= w_cap_eff) && w_res.vic_found;

    always_comb begin
        if (!w_res.free_found) begin
            w_ins_idx = w_vic_idx[ENTRIES];
        end else if (w_evict && (w_vic_idx[ENTRIES] < w_free_idx[ENTRIES])) begin
            w_ins_idx = w_vic_idx[ENTRIES];
        end else begin
            w_ins_idx = w_free_idx[ENTRIES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_last) begin
            r_hit          <= w_res.found;
            r_rdval        <= (r_op == OP_LOOKUP && w_res.found) ? w_res.hit_value : '0;
            r_cmd.is_write <= (r_op == OP_WRITE);
            r_cmd.evict    <= w_evict;
            r_cmd.key      <= r_key;
            r_cmd.value    <= r_wval;
            r_cmd_vidx     <= w_vic_idx[ENTRIES];
            r_cmd_vrank    <= w_vic_rank[ENTRIES];
            r_cmd_rank     <= w_hit_rank[ENTRIES];
            if (w_res.found) begin
                r_cmd_idx <= w_hit_idx[ENTRIES];
            end else begin
                r_cmd_idx <= w_ins_idx;
            end
            if (r_op == OP_LOOKUP) begin
                r_cmd.kind <= w_res.found ? CMD_BUMP : CMD_NONE;
            end else if (r_capacity == '0) begin
                r_cmd.kind <= CMD_NONE;
            end else if (w_res.found) begin
                r_cmd.kind <= CMD_BUMP;
            end else begin
                r_cmd.kind <= CMD_INSERT;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_hit  <= r_hit;
            r_out_data <= r_rdval;
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_hit;

    `LFU_ASSERT(a_accept_starts_sweep, w_accept |=> (r_state == ST_SWEEP), "sweep did not start")
    `LFU_ASSERT(a_token_in_sweep, w_last |-> (r_state == ST_SWEEP), "search token outside sweep")
    `LFU_ASSERT(a_result_from_resp, $rose(o_m_tvalid) |-> ($past(r_state) == ST_RESP), "result without item")
    `LFU_ASSERT_ALWAYS(a_reset_clears, !i_rst_n |=> (!o_m_tvalid && o_s_tready), "reset not applied")

endmodule

/* tb/sv/lfu_cache_test.sv */
module lfu_cache_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lfu_pkg::*;

    localparam int ENTRIES     = 16;
    localparam int COUNT_TOP   = 65535;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int PHASE_ITEMS = 150;

    // expected outcome of one access
    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] read_value;
    } t_access_result;

    // Shadow copy of the store: predicts each access and checks the returned items.
    class lfu_scoreboard;
        bit               slot_valid [ENTRIES];
        bit [KEY_W-1:0]   slot_key   [ENTRIES];
        bit [VAL_W-1:0]   slot_value [ENTRIES];
        bit [CNT_W-1:0]   slot_count [ENTRIES];
        int unsigned      slot_age   [ENTRIES];
        bit [CAP_W-1:0]   capacity = CAP_RESET;
        t_access_result   awaited[$];
        int               errors;
        int               checked;
        int               hits;
        int               evictions;

        function void set_capacity(input logic [CAP_W-1:0] cap);
            capacity = cap;
        endfunction

        // most recent becomes age 0; younger valid entries age by one
        function void touch_slot(input int s);
            for (int i = 0; i < ENTRIES; i++) begin
                if (i != s && slot_valid[i] && slot_age[i] < slot_age[s])
                    slot_age[i]++;
            end
            slot_age[s] = 0;
        endfunction

        function void bump_slot(input int s);
            if (slot_count[s] != COUNT_TOP[CNT_W-1:0])
                slot_count[s]++;
            touch_slot(s);
        endfunction

        function void note_item(input logic op, input logic [KEY_W-1:0] k,
                                input logic [VAL_W-1:0] v);
            int             s;
            int             victim;
            int             free_slot;
            int unsigned    nvalid;
            int unsigned    cap;
            t_access_result r;
            s = -1;
            for (int i = 0; i < ENTRIES; i++) begin
                if (s < 0 && slot_valid[i] && slot_key[i] == k)
                    s = i;
            end
            cap = (capacity > ENTRIES) ? ENTRIES : capacity;
            r.hit = (s >= 0);
            r.read_value = '0;
            if (op == OP_LOOKUP) begin
                if (s >= 0) begin
                    r.read_value = slot_value[s];
                    bump_slot(s);
                end
            end else if (cap != 0) begin
                if (s >= 0) begin
                    slot_value[s] = v;
                    bump_slot(s);
                end else begin
                    nvalid = 0;
                    for (int i = 0; i < ENTRIES; i++)
                        if (slot_valid[i]) nvalid++;
                    // full: drop lowest count, oldest on a tie
                    if (nvalid >= cap) begin
                        victim = -1;
                        for (int i = 0; i < ENTRIES; i++) begin
                            if (slot_valid[i] && (victim < 0 ||
                                    slot_count[i] < slot_count[victim] ||
                                    (slot_count[i] == slot_count[victim] &&
                                     slot_age[i] > slot_age[victim])))
                                victim = i;
                        end
                        for (int i = 0; i < ENTRIES; i++) begin
                            if (i != victim && slot_valid[i] &&
                                    slot_age[i] > slot_age[victim])
                                slot_age[i]--;
                        end
                        slot_valid[victim] = 0;
                        evictions++;
                    end
                    free_slot = -1;
                    for (int i = 0; i < ENTRIES; i++)
                        if (free_slot < 0 && !slot_valid[i]) free_slot = i;
                    if (free_slot >= 0) begin
                        slot_valid[free_slot] = 1;
                        slot_key[free_slot]   = k;
                        slot_value[free_slot] = v;
                        slot_count[free_slot] = CNT_W'(1);
                        slot_age[free_slot]   = ENTRIES - 1;
                        touch_slot(free_slot);
                    end
                end
            end
            if (r.hit) hits++;
            awaited.push_back(r);
        endfunction

        function void check_result(input logic hit, input logic [VAL_W-1:0] rv);
            t_access_result e;
            if (awaited.size() == 0) begin
                $error("result with nothing awaited: hit %0b read_value %0h", hit, rv);
                errors++;
                return;
            end
            e = awaited.pop_front();
            checked++;
            if (hit !== e.hit) begin
                $error("hit mismatch: expected %0b, got %0b", e.hit, hit);
                errors++;
            end
            if (rv !== e.read_value) begin
                $error("read_value mismatch: expected %0d, got %0d",
                       $signed(e.read_value), $signed(rv));
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wen;
    logic [4:0]  i_cfg_wdata;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [63:0] i_s_tdata;   // [31:0] key, [63:32] write_value
    logic        i_s_tuser;   // [0] opcode
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [31:0] o_m_tdata;   // [31:0] read_value
    logic        o_m_tuser;   // [0] hit

    lfu_scoreboard sb = new;
    int            tx_idle_pct;
    int            rx_stall_pct;
    int            hold_requests;
    int            cycles;

    lfu_cache #(
        .ENTRIES (ENTRIES)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // watchdog
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiving side: check accepted items, then pick next tready
    initial begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready)
                sb.check_result(o_m_tuser, o_m_tdata);
            if (hold_requests != hold_seen) begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // offer one item, with random gaps beforehand; returns after acceptance
    task automatic send_item(input logic op, input logic [KEY_W-1:0] k,
                             input logic [VAL_W-1:0] v);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {v, k};
        i_s_tuser  <= op;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_item(op, k, v);
    endtask

    // stop offering and wait for every awaited item to come back
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        drain_results();
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= cap;
        @(posedge i_clk);
        i_cfg_wen   <= 1'b0;
        sb.set_capacity(cap);
    endtask

    initial begin
        logic [KEY_W-1:0] key_pool [20];
        int               phase_cap    [8];
        int               phase_idle   [8];
        int               phase_stall  [8];
        logic             op;
        logic [KEY_W-1:0] k;

        phase_cap     = '{16, 31, 1, 4, 0, 8, 17, 99};
        phase_idle    = '{0, 70, 0, 23, 0, 70, 0, 23};
        phase_stall   = '{0, 0, 70, 23, 0, 0, 70, 23};
        i_rst_n       <= 1'b0;
        i_cfg_wen     <= 1'b0;
        i_cfg_wdata   <= '0;
        i_s_tvalid    <= 1'b0;
        i_s_tdata     <= '0;
        i_s_tuser     <= OP_LOOKUP;
        tx_idle_pct   = 0;
        rx_stall_pct  = 0;
        hold_requests = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty miss, extreme keys and values, update of a present key
        send_item(OP_LOOKUP, 32'h0000_0000, 32'h0);
        send_item(OP_WRITE,  32'h0000_0000, 32'h7FFF_FFFF);
        send_item(OP_WRITE,  32'hFFFF_FFFF, 32'h8000_0000);
        send_item(OP_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
        send_item(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0);
        send_item(OP_WRITE,  32'h0000_0000, 32'hFFFF_FFFF);
        send_item(OP_LOOKUP, 32'h0000_0000, 32'h0);
        send_item(OP_LOOKUP, 32'h1234_5678, 32'h0);
        // full at two: the less used key goes
        write_capacity(5'd2);
        send_item(OP_WRITE,  32'h0000_0005, 32'h0000_0055);
        send_item(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0);
        // capacity zero: writes change nothing but still report presence
        write_capacity(5'd0);
        send_item(OP_WRITE,  32'h0000_0007, 32'h0000_0077);
        send_item(OP_WRITE,  32'h0000_0005, 32'hDEAD_BEEF);
        send_item(OP_LOOKUP, 32'h0000_0005, 32'h0);
        send_item(OP_LOOKUP, 32'h0000_0007, 32'h0);
        // capacity below the entries held: one out, one in
        write_capacity(5'd1);
        send_item(OP_WRITE,  32'h0000_0009, 32'h0000_0099);
        send_item(OP_LOOKUP, 32'h0000_0000, 32'h0);
        send_item(OP_LOOKUP, 32'h0000_0005, 32'h0);
        send_item(OP_LOOKUP, 32'h0000_0009, 32'h0);

        // random phases: a small key pool keeps hits and evictions frequent
        for (int p = 0; p < 8; p++) begin
            write_capacity(CAP_W'((phase_cap[p] > 31) ? $urandom_range(31) : phase_cap[p]));
            tx_idle_pct  = phase_idle[p];
            rx_stall_pct = phase_stall[p];
            for (int j = 0; j < 20; j++) begin
                case ($urandom_range(9))
                    0:       key_pool[j] = 32'h0000_0000;
                    1:       key_pool[j] = 32'hFFFF_FFFF;
                    default: key_pool[j] = $urandom;
                endcase
            end
            // long output hold-off so the block backs up and stalls its input
            if (p == 4) hold_requests++;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                op = ($urandom_range(99) < 45) ? OP_WRITE : OP_LOOKUP;
                k  = ($urandom_range(99) < 85) ? key_pool[$urandom_range(19)] : $urandom;
                send_item(op, k, $urandom);
            end
        end

        drain_results();
        repeat (ENTRIES + 8) @(posedge i_clk);
        if (sb.awaited.size() != 0) begin
            $error("%0d results never arrived", sb.awaited.size());
            sb.errors++;
        end
        $display("Checked %0d results (%0d hits, %0d evictions) over capacities 0 to 31,",
                 sb.checked, sb.hits, sb.evictions);
        $display("drained capacity changes, a long output hold-off and idle/stall mixes.");
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
